FILE: rtl/stbs_pkg.sv
`default_nettype none

package stbs_pkg;

    // field widths fixed by the interface
    localparam int unsigned LEN_W = 15;
    localparam int unsigned IDX_W = 14;
    localparam int unsigned VAL_W = 32;

    // request kinds
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // one request: a table load or a key search
    typedef struct packed {
        logic                    req_type;
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] entry_value;
        logic signed [VAL_W-1:0] search_key;
    } req_t;

    // one search answer
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
    } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/sorted_table_binary_search_top.sv
// Binary search over a table of signed 32-bit values held in one on-chip RAM.
// A request with req_type load writes entry_value at entry_index,
// gives no answer, and leaves busy low; loads beyond TABLE_DEPTH are dropped.
// A search request raises busy for a setup state and the probes that follow,
// at most floor(log2(TABLE_DEPTH)) + 1 of them; the RAM's single registered
// read port feeds the compare directly and so gives one
// probe per cycle. The answer comes on result with done high for exactly one
// cycle, in the cycle busy falls, and must be taken then: there is no way to
// hold it. The table must be loaded in ascending order before it is searched,
// and only entries below table_length (written through cfg_we / cfg_wdata,
// capped at TABLE_DEPTH) take part. Write table_length only while no search
// is running. No clearing pass runs after reset.
`default_nettype none

module sorted_table_binary_search_top #(
    parameter int unsigned TABLE_DEPTH = 16384
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire stbs_pkg::req_t                req,
    output logic                               done,
    output stbs_pkg::rsp_t                     result,
    input  wire logic                          cfg_we,
    input  wire logic [stbs_pkg::LEN_W-1:0]    cfg_wdata
);

    import stbs_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned LW = $clog2(TABLE_DEPTH + 1);

    logic [LEN_W-1:0]        table_length_reg;
    logic                    accept;
    logic                    load_we;
    logic [AW-1:0]           load_addr;
    logic [31:0]             len_wide;
    logic [LW-1:0]           len_clamped;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic signed [VAL_W-1:0] rd_data;

    // length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            table_length_reg <= cfg_wdata;
        end
    end

    // request decode
    assign accept    = start && !busy;
    assign load_we   = accept && (req.req_type == REQ_LOAD)
                       && (32'(req.entry_index) < 32'(TABLE_DEPTH));
    assign load_addr = AW'(req.entry_index);

    // live length capped at the table depth
    assign len_wide    = 32'(table_length_reg);
    assign len_clamped = (len_wide > 32'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : LW'(len_wide);

    stbs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_addr),
        .wdata (req.entry_value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    stbs_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .search_start (accept && (req.req_type == REQ_SEARCH)),
        .key          (req.search_key),
        .len          (len_clamped),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .busy         (busy),
        .done         (done),
        .result       (result)
    );

    // a miss always reports index zero
    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.match_index == '0))
        else $error("miss reported with nonzero index");

    // an accepted search occupies the block next cycle
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.req_type == REQ_SEARCH)) |=> busy)
        else $error("search accepted but block not busy");

    // answers never come in consecutive cycles
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two answers in a row");

    // an answer only ends a running search
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("answer without a running search");

endmodule

`default_nettype wire

FILE: rtl/stbs_ram.sv
`default_nettype none

module stbs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/stbs_ctrl.sv
`default_nettype none

module stbs_ctrl #(
    parameter int unsigned TABLE_DEPTH = 16384
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 search_start,
    input  wire logic signed [stbs_pkg::VAL_W-1:0]    key,
    input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]     len,
    output logic                                      rd_en,
    output logic      [$clog2(TABLE_DEPTH)-1:0]       rd_addr,
    input  wire logic signed [stbs_pkg::VAL_W-1:0]    rd_data,
    output logic                                      busy,
    output logic                                      done,
    output stbs_pkg::rsp_t                            result
);

    import stbs_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned LW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [LW-1:0]           lo_reg, lo_next;
    logic [LW-1:0]           end_reg, end_next;
    logic [AW-1:0]           mid_reg, mid_next;
    logic signed [VAL_W-1:0] key_reg, key_next;
    logic                    done_reg, done_next;
    rsp_t                    result_reg, result_next;

    logic [LW-1:0] mid_w;
    logic [LW-1:0] setup_mid;
    logic [LW-1:0] up_lo;
    logic          up_empty;
    logic [LW-1:0] up_mid;
    logic          dn_empty;
    logic [LW-1:0] dn_mid;

    // candidate midpoints for both halves, built beside the compare
    always_comb
    begin
        mid_w     = LW'(mid_reg);
        setup_mid = lo_reg + ((end_reg - LW'(1) - lo_reg) >> 1);
        up_lo     = mid_w + LW'(1);
        up_empty  = (up_lo >= end_reg);
        up_mid    = up_lo + ((end_reg - up_lo - LW'(1)) >> 1);
        dn_empty  = (lo_reg >= mid_w);
        dn_mid    = lo_reg + ((mid_w - LW'(1) - lo_reg) >> 1);
    end

    // search sequencer: one probe issued per cycle
    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        end_next    = end_reg;
        mid_next    = mid_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        rd_en       = 1'b0;
        rd_addr     = mid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (search_start)
                begin
                    key_next   = key;
                    lo_next    = '0;
                    end_next   = len;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (lo_reg < end_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(setup_mid);
                    mid_next   = AW'(setup_mid);
                    state_next = ST_PROBE;
                end
                else
                begin
                    done_next   = 1'b1;
                    result_next = '{found: 1'b0, match_index: '0};
                    state_next  = ST_IDLE;
                end
            end
            ST_PROBE:
            begin
                if (rd_data == key_reg)
                begin
                    done_next   = 1'b1;
                    result_next = '{found: 1'b1, match_index: IDX_W'(mid_reg)};
                    state_next  = ST_IDLE;
                end
                else if (rd_data < key_reg)
                begin
                    // keep upper half
                    lo_next = up_lo;
                    if (up_empty)
                    begin
                        done_next   = 1'b1;
                        result_next = '{found: 1'b0, match_index: '0};
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(up_mid);
                        mid_next = AW'(up_mid);
                    end
                end
                else
                begin
                    // keep lower half
                    end_next = mid_w;
                    if (dn_empty)
                    begin
                        done_next   = 1'b1;
                        result_next = '{found: 1'b0, match_index: '0};
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(dn_mid);
                        mid_next = AW'(dn_mid);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // search range and answer
    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        end_reg    <= end_next;
        mid_reg    <= mid_next;
        key_reg    <= key_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: bench/sorted_table_binary_search_top_tb.sv
`default_nettype none

module sorted_table_binary_search_top_tb;

    import stbs_pkg::*;

    localparam int TABLE_DEPTH   = 16384;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1050;
    localparam int REWRITE_MAX   = 64;
    localparam int REPORT_MAX    = 100;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    req_t             req = '0;
    logic             done;
    rsp_t             result;
    logic             cfg_we = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;

    // local copy of the table and the length register
    logic signed [VAL_W-1:0] sorted_copy [TABLE_DEPTH];
    logic [LEN_W-1:0]        table_len = '0;

    rsp_t pending_answers [$];
    int   error_count  = 0;
    int   sent_items   = 0;
    int   stall_cycles = 0;
    bit   idling_on    = 1'b1;

    sorted_table_binary_search_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // probe order of the hardware search over the local table copy
    function automatic rsp_t lookup_key(input logic signed [VAL_W-1:0] key);
        rsp_t ans;
        int   span;
        int   lo;
        int   hi_end;
        int   mid;
        ans    = '0;
        span   = (int'(table_len) > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_len);
        lo     = 0;
        hi_end = span;
        while (lo < hi_end)
        begin
            mid = lo + (hi_end - 1 - lo) / 2;
            if (sorted_copy[mid] == key)
            begin
                ans.found       = 1'b1;
                ans.match_index = mid[IDX_W-1:0];
                return ans;
            end
            if (sorted_copy[mid] < key)
                lo = mid + 1;
            else
                hi_end = mid;
        end
        return ans;
    endfunction

    // ascending line of values over the whole depth, pinned at both ends
    function automatic logic signed [VAL_W-1:0] line_value(input int i);
        longint v;
        v = longint'(i) * 262144 - 64'sd2147483648;
        if (i == TABLE_DEPTH - 1)
            v = VAL_MAX;
        return v[VAL_W-1:0];
    endfunction

    function automatic req_t load_req(input int idx, input logic signed [VAL_W-1:0] val);
        req_t r;
        r.req_type    = REQ_LOAD;
        r.entry_index = idx[IDX_W-1:0];
        r.entry_value = val;
        r.search_key  = $signed($urandom());
        return r;
    endfunction

    function automatic req_t search_req(input logic signed [VAL_W-1:0] key);
        req_t r;
        r.req_type    = REQ_SEARCH;
        r.entry_index = IDX_W'($urandom_range(TABLE_DEPTH - 1));
        r.entry_value = $signed($urandom());
        r.search_key  = key;
        return r;
    endfunction

    // drive one request, starting and ending at a falling edge
    task automatic send_request(input req_t r);
        if (idling_on)
        begin
            start = 1'b0;
            while ($urandom_range(99) < 30)
                @(negedge clk);
        end
        req   = r;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // accepted at this edge
        sent_items++;
        if (r.req_type == REQ_LOAD)
            sorted_copy[r.entry_index] = r.entry_value;
        else
            pending_answers.push_back(lookup_key(r.search_key));
        @(negedge clk);
        start = 1'b0;
    endtask

    // length register may only change while no search is in flight
    task automatic write_table_length(input int len);
        while (pending_answers.size() != 0 || busy)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wdata = len[LEN_W-1:0];
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        table_len = len[LEN_W-1:0];
    endtask

    // load every entry a search for the target index probes, with line values
    task automatic load_probe_path(input int span, input int target);
        int lo;
        int hi_end;
        int mid;
        bit hit;
        lo     = 0;
        hi_end = span;
        hit    = 1'b0;
        while (lo < hi_end && !hit)
        begin
            mid = lo + (hi_end - 1 - lo) / 2;
            send_request(load_req(mid, line_value(mid)));
            if (mid == target)
                hit = 1'b1;
            else if (mid < target)
                lo = mid + 1;
            else
                hi_end = mid;
        end
    endtask

    // search a line value and the gap just above it, both probe paths loaded
    task automatic search_line(input int span, input int target);
        load_probe_path(span, target);
        if (target + 1 < span)
            load_probe_path(span, target + 1);
        send_request(search_req(line_value(target)));
        if (target != TABLE_DEPTH - 1)
            send_request(search_req(line_value(target) + 32'sd1));
    endtask

    // check every answer against the oldest prediction
    always @(posedge clk)
    begin : answer_check
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("%0t: unexpected answer found=%0b match_index=%0d",
                             $time, result.found, result.match_index);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (result.found !== want.found)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("%0t: found expected %0b actual %0b",
                                 $time, want.found, result.found);
                end
                if (result.match_index !== want.match_index)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("%0t: match_index expected %0d actual %0d",
                                 $time, want.match_index, result.match_index);
                end
            end
        end
    end

    // watchdog on cycles with no request and no answer moving
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // zero length right after reset: nothing is probed
    task automatic test_empty_table();
        send_request(search_req(VAL_MIN));
        send_request(search_req(VAL_MAX));
        send_request(search_req(32'sd0));
    endtask

    // full depth over an ascending line, only the probed entries loaded
    task automatic test_full_table();
        idling_on = 1'b0;
        write_table_length(TABLE_DEPTH);
        search_line(TABLE_DEPTH, 0);
        search_line(TABLE_DEPTH, TABLE_DEPTH - 1);
        search_line(TABLE_DEPTH, TABLE_DEPTH / 2 - 1);
        idling_on = 1'b1;
        search_line(TABLE_DEPTH, 1);
        search_line(TABLE_DEPTH, 100);
        search_line(TABLE_DEPTH, TABLE_DEPTH - 2);
        send_request(search_req(VAL_MAX - 32'sd1));
        // above the depth the length is capped
        write_table_length(32767);
        search_line(TABLE_DEPTH, 12345);
        search_line(TABLE_DEPTH, TABLE_DEPTH - 1);
    endtask

    // one, two and three entries
    task automatic test_short_tables();
        send_request(load_req(0, 32'sd5));
        send_request(load_req(1, 32'sd7));
        send_request(load_req(2, 32'sd9));
        for (int len = 1; len <= 3; len++)
        begin
            write_table_length(len);
            send_request(search_req(sorted_copy[len - 1]));
            send_request(search_req(32'sd4));
        end
        send_request(search_req(32'sd6));
    endtask

    // duplicate keys and a table loaded out of order
    task automatic test_duplicates_and_unsorted();
        logic signed [VAL_W-1:0] dups [7] = '{-32'sd3, -32'sd3, 32'sd2, 32'sd2, 32'sd2,
                                             32'sd2, 32'sd9};
        write_table_length(7);
        for (int i = 0; i < 7; i++)
            send_request(load_req(i, dups[i]));
        send_request(search_req(32'sd2));
        send_request(search_req(-32'sd3));
        send_request(search_req(32'sd9));
        for (int i = 0; i < 7; i++)
            send_request(load_req(i, 32'sd70 - 32'sd10 * i));
        send_request(search_req(32'sd10));
        send_request(search_req(32'sd70));
    endtask

    // phases of a fresh length, a freshly loaded table, then searches
    task automatic test_random_phases();
        int     first_item;
        int     phase;
        int     pick;
        int     len;
        int     span;
        int     fill;
        int     searches;
        int     step_max;
        bit     scrambled;
        longint v;
        logic signed [VAL_W-1:0] key;
        first_item = sent_items;
        phase      = 0;
        while (sent_items - first_item < RANDOM_ITEMS)
        begin
            // long stretch with no gaps every fourth phase
            idling_on = (phase % 4 != 3);
            pick = $urandom_range(99);
            if (pick < 8)
                len = 0;
            else if (pick < 16)
                len = TABLE_DEPTH;
            else if (pick < 22)
                len = 32767;
            else if (pick < 28)
                len = 1;
            else if (pick < 36)
                len = $urandom_range(32767, 65);
            else
                len = $urandom_range(REWRITE_MAX, 2);
            write_table_length(len);
            span = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;

            if (span > REWRITE_MAX)
            begin
                // long table: line values along the probe paths of a few targets
                searches = $urandom_range(4, 1);
                for (int n = 0; n < searches; n++)
                    search_line(span, $urandom_range(span - 1));
            end
            else
            begin
                fill = span;

                // sorted table with random spacing, sometimes scrambled
                scrambled = ($urandom_range(9) == 0);
                case ($urandom_range(2))
                    0: step_max = 1;
                    1: step_max = 100;
                    default: step_max = 1 << 24;
                endcase
                v = $signed($urandom());
                if (v > 0)
                    v = -v;
                for (int i = 0; i < fill; i++)
                begin
                    if (scrambled)
                        v = $signed($urandom());
                    else if (i > 0)
                        v = v + $urandom_range(step_max);
                    if (v > VAL_MAX)
                        v = VAL_MAX;
                    send_request(load_req(i, v[VAL_W-1:0]));
                end

                searches = $urandom_range(40, 10);
                for (int n = 0; n < searches; n++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 10)
                        // stray load that may break the order
                        send_request(load_req($urandom_range((span > 0) ? span - 1 : 0),
                                              $signed($urandom())));
                    else
                    begin
                        if (span == 0)
                            key = $signed($urandom());
                        else if (pick < 55)
                            key = sorted_copy[$urandom_range((fill > 0) ? fill - 1 : 0)];
                        else if (pick < 65)
                            key = sorted_copy[$urandom_range(span - 1)];
                        else if (pick < 80)
                            key = sorted_copy[$urandom_range(span - 1)]
                                  + ($urandom_range(1) ? 32'sd1 : -32'sd1);
                        else if (pick < 90)
                            key = $signed($urandom());
                        else
                            key = $urandom_range(1) ? VAL_MIN : VAL_MAX;
                        send_request(search_req(key));
                    end
                end
            end
            phase++;
        end
        idling_on = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_table();
        test_full_table();
        test_short_tables();
        test_duplicates_and_unsorted();
        test_random_phases();

        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sorted_table_binary_search_top.f
rtl/stbs_pkg.sv
rtl/stbs_ram.sv
rtl/stbs_ctrl.sv
rtl/sorted_table_binary_search_top.sv
bench/sorted_table_binary_search_top_tb.sv
